// File: hdl/ltsf_pkg.sv
`default_nettype none

package ltsf_pkg;

	// Default sizes for the top-level parameters
	localparam int PATTERN_MAX_DEF = 16;
	localparam int MESSAGE_MAX_DEF = 4096;

	// Fixed field and port widths
	localparam int CHAR_W     = 8;
	localparam int POS_OUT_W  = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PAT_VEC_W  = 128;
	localparam int PLEN_W     = 5;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLED = 3'd0,
		REG_PATTERN_LOW    = 3'd1,
		REG_PATTERN_HIGH   = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_CASE_SENSITIVE = 3'd4,
		REG_WHOLE_WORD     = 3'd5
	} cfg_reg_t;

	// Window compare result handed to the control logic
	typedef struct packed {
		logic hit;          // pattern ends on the current byte
		logic border_alnum; // byte just before the occurrence is alphanumeric
	} match_t;

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// Fold A-Z onto a-z unless the compare is case sensitive
	function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c,
			input logic case_sens);
		logic [CHAR_W-1:0] r;
		r = c;
		if (!case_sens && c >= 8'h41 && c <= 8'h5A)
			r = c + 8'd32;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/ltsf_if.sv
`default_nettype none

// Message byte channel
interface ltsf_msg_if import ltsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_character;

	modport source (output valid, character, last_character, input ready);
	modport sink (input valid, character, last_character, output ready);
endinterface

// Per-message verdict channel
interface ltsf_verdict_if import ltsf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic [POS_OUT_W-1:0] match_position;

	modport source (output valid, accepted, match_position, input ready);
	modport sink (input valid, accepted, match_position, output ready);
endinterface

`default_nettype wire

// File: hdl/ltsf_match.sv
`default_nettype none

// Parallel compare of the current byte plus the recent-byte window against
// the right-aligned pattern. One lane per pattern position.
module ltsf_match import ltsf_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int LW = $clog2(PATTERN_MAX + 1),
	parameter int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  logic [CHAR_W-1:0]    cur,
	input  logic [CHAR_W-1:0]    window [0:PATTERN_MAX-1],
	input  logic [PAT_VEC_W-1:0] pattern,
	input  logic [LW-1:0]        len,
	input  logic                 case_sens,
	output match_t               result
);

	logic [CHAR_W-1:0]      pat_byte [0:PATTERN_MAX-1];
	logic [PATTERN_MAX-1:0] lane_ok;
	logic [IW-1:0]          border_idx;

	// Pattern bytes past the register pair read as zero
	for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pat
		if (p * CHAR_W < PAT_VEC_W) begin : g_live
			assign pat_byte[p] = pattern[p*CHAR_W +: CHAR_W];
		end else begin : g_zero
			assign pat_byte[p] = '0;
		end
	end

	// Lane k looks k bytes back and checks pattern byte len-1-k
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_lane
		logic [CHAR_W-1:0] txt;
		logic [IW-1:0]     pidx;
		logic              active;

		if (k == 0) begin : g_cur
			assign txt = cur;
		end else begin : g_win
			assign txt = window[k-1];
		end

		assign active = LW'(k) < len;
		assign pidx   = IW'(len - LW'(k + 1));
		assign lane_ok[k] = !active ||
			(fold_byte(txt, case_sens) == fold_byte(pat_byte[pidx], case_sens));
	end

	// Byte just before the occurrence start sits len positions back
	assign border_idx = (len == '0) ? '0 : IW'(len - LW'(1));

	assign result.hit          = &lane_ok;
	assign result.border_alnum = is_alnum(window[border_idx]);

endmodule

`default_nettype wire

// File: hdl/log_text_substring_filter.sv
`default_nettype none

// Channel   Dir  Payload                                  Request
// msg       in   character[7:0], last_character           one message byte
// verdict   out  accepted, match_position[11:0]           one per message
// cfg_*     in   cfg_index[2:0], cfg_wdata[63:0]           register write
//
// Each byte sits in the input register, where the window compare
// and match bookkeeping run; a message's last byte then loads the verdict register.
// One byte per cycle sustained while the verdict register is not stalled.
// A stalled verdict holds the input register only when its byte ends a message.
// Reset clears all control state and configuration; no clearing pass.
module log_text_substring_filter import ltsf_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int MESSAGE_MAX = MESSAGE_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	ltsf_msg_if.sink                   msg,
	ltsf_verdict_if.source             verdict
);

	localparam int LW  = $clog2(PATTERN_MAX + 1);
	localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int PW  = $clog2(MESSAGE_MAX + 1);  // byte count, saturating
	localparam int FW  = $clog2(MESSAGE_MAX);      // reported start offset
	localparam int CW  = ((PW > LW) ? PW : LW) + 1;
	localparam int LXW = (LW > PLEN_W) ? LW : PLEN_W;

	// Configuration registers
	logic                  filt_en_q;
	logic [PAT_VEC_W-1:0]  pattern_q;
	logic [PLEN_W-1:0]     plen_q;
	logic                  case_sens_q;
	logic                  whole_word_q;

	// Input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// Per-message search state
	logic [CHAR_W-1:0] window_q [0:PATTERN_MAX-1];
	logic [PW-1:0]     count_q;
	logic              found_q;
	logic [FW-1:0]     found_pos_q;
	logic              pend_q;
	logic [FW-1:0]     pend_pos_q;

	// Verdict register
	logic                 out_valid_q;
	logic                 out_acc_q;
	logic [POS_OUT_W-1:0] out_pos_q;

	logic              out_free;
	logic              go;
	logic [LW-1:0]     len;
	logic [LXW-1:0]    plen_x;
	match_t            cmp;
	logic [CW-1:0]     count_x;
	logic              enough;
	logic              start_zero;
	logic [CW-1:0]     start_x;
	logic [FW-1:0]     cand_pos;
	logic              left_ok;
	logic              found_n;
	logic [FW-1:0]     found_pos_n;
	logic              pend_n;
	logic [FW-1:0]     pend_pos_n;
	logic [PW-1:0]     count_n;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_en_q    <= 1'b0;
			pattern_q    <= '0;
			plen_q       <= '0;
			case_sens_q  <= 1'b0;
			whole_word_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FILTER_ENABLED: filt_en_q <= cfg_wdata[0];
				REG_PATTERN_LOW:    pattern_q[CFG_DATA_W-1:0] <= cfg_wdata;
				REG_PATTERN_HIGH:   pattern_q[PAT_VEC_W-1:CFG_DATA_W] <= cfg_wdata;
				REG_PATTERN_LENGTH: plen_q <= cfg_wdata[PLEN_W-1:0];
				REG_CASE_SENSITIVE: case_sens_q <= cfg_wdata[0];
				REG_WHOLE_WORD:     whole_word_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: a byte moves on unless it ends a message and the verdict is stuck
	assign out_free  = !out_valid_q || verdict.ready;
	assign go        = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			char_s1 <= msg.character;
			last_s1 <= msg.last_character;
		end
	end

	// Clamp the configured length to the pattern capacity
	assign plen_x = LXW'(plen_q);
	assign len    = (plen_x > LXW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(plen_x);

	ltsf_match #(
		.PATTERN_MAX(PATTERN_MAX),
		.LW(LW),
		.IW(IW)
	) u_match (
		.cur(char_s1),
		.window(window_q),
		.pattern(pattern_q),
		.len(len),
		.case_sens(case_sens_q),
		.result(cmp)
	);

	// Occurrence start and its reported offset
	assign count_x    = CW'(count_q) + CW'(1);
	assign enough     = count_x >= CW'(len);
	assign start_zero = count_x == CW'(len);
	assign start_x    = count_x - CW'(len);
	assign cand_pos   = (count_q == PW'(MESSAGE_MAX)) ? FW'(MESSAGE_MAX - 1) : FW'(start_x);
	assign left_ok    = start_zero || !cmp.border_alnum;
	assign count_n    = (count_q == PW'(MESSAGE_MAX)) ? count_q : count_q + PW'(1);

	// Match bookkeeping for the byte in the input register
	always_comb begin
		found_n     = found_q;
		found_pos_n = found_pos_q;
		pend_n      = 1'b0;
		pend_pos_n  = pend_pos_q;

		// A whole-word candidate is confirmed by a non-alphanumeric follower
		if (pend_q && !found_q && !is_alnum(char_s1)) begin
			found_n     = 1'b1;
			found_pos_n = pend_pos_q;
		end

		if (!found_n) begin
			if (len == '0) begin
				found_n     = 1'b1;
				found_pos_n = '0;
			end else if (enough && cmp.hit) begin
				if (!whole_word_q) begin
					found_n     = 1'b1;
					found_pos_n = cand_pos;
				end else if (left_ok) begin
					if (last_s1) begin
						found_n     = 1'b1;
						found_pos_n = cand_pos;
					end else begin
						pend_n     = 1'b1;
						pend_pos_n = cand_pos;
					end
				end
			end
		end
	end

	// Search state; everything returns to zero after a message's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_q     <= 1'b0;
			found_pos_q <= '0;
			pend_q      <= 1'b0;
			pend_pos_q  <= '0;
		end else if (go) begin
			if (last_s1) begin
				count_q     <= '0;
				found_q     <= 1'b0;
				found_pos_q <= '0;
				pend_q      <= 1'b0;
				pend_pos_q  <= '0;
			end else begin
				count_q     <= count_n;
				found_q     <= found_n;
				found_pos_q <= found_pos_n;
				pend_q      <= pend_n;
				pend_pos_q  <= pend_pos_n;
			end
		end
	end

	// Recent-byte window, most recent first
	always_ff @(posedge clk) begin
		if (go) begin
			window_q[0] <= char_s1;
			for (int i = 1; i < PATTERN_MAX; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			out_acc_q <= !filt_en_q || found_n;
			out_pos_q <= (filt_en_q && found_n) ? POS_OUT_W'(found_pos_n) : '0;
		end
	end

	assign verdict.valid          = out_valid_q;
	assign verdict.accepted       = out_acc_q;
	assign verdict.match_position = out_pos_q;

endmodule

`default_nettype wire
